>>> rtl/spid_pkg.sv
package spid_pkg;

   // Field widths
   localparam int SAMPLE_W = 15;
   localparam int GAIN_W   = 16;
   localparam int DIFF_W   = 18;
   localparam int TERM_W   = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default term limits
   localparam int P_TERM_LIMIT_DEF = 2000;
   localparam int I_TERM_LIMIT_DEF = 2000;
   localparam int D_TERM_LIMIT_DEF = 2000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MAX = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] STEP_LIMIT_RST = 15'd1000;
   localparam logic [SAMPLE_W-1:0] OUTPUT_MAX_RST = 15'd5000;

   typedef logic        [SAMPLE_W-1:0]   sample_type;
   typedef logic signed [GAIN_W-1:0]     gain_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [TERM_W-1:0]     term_type;
   typedef logic        [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic        [CSR_DATA_W-1:0] csr_data_type;

endpackage

>>> rtl/spid_if.sv
interface spid_req_if;
   import spid_pkg::*;
   logic       valid;
   logic       ready;
   sample_type measured_speed;
   modport source (output valid, output measured_speed, input ready);
   modport sink   (input valid, input measured_speed, output ready);
endinterface

interface spid_rsp_if;
   import spid_pkg::*;
   logic       valid;
   logic       ready;
   sample_type drive_duty;
   modport source (output valid, output drive_duty, input ready);
   modport sink   (input valid, input drive_duty, output ready);
endinterface

interface spid_csr_if;
   import spid_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/spid_term.sv
module spid_term #(
   parameter int LIMIT = spid_pkg::P_TERM_LIMIT_DEF
) (
   input  spid_pkg::gain_type gain,
   input  spid_pkg::diff_type diff,
   output spid_pkg::term_type term_out
);
   import spid_pkg::*;

   localparam int PROD_W = GAIN_W + DIFF_W;
   localparam int QUOT_W = PROD_W - 8;
   localparam logic signed [QUOT_W-1:0] LIM_POS = QUOT_W'(LIMIT);
   localparam logic signed [QUOT_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] biased;
   logic signed [QUOT_W-1:0] quot;

   // Q8.8 gain times the integer difference, divided by 256 rounding toward zero
   assign prod   = gain * diff;
   assign biased = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
   assign quot   = biased[PROD_W-1:8];

   // Saturate to the symmetric term limit
   always_comb begin
      priority if (quot > LIM_POS) begin
         term_out = LIM_POS[TERM_W-1:0];
      end else if (quot < LIM_NEG) begin
         term_out = LIM_NEG[TERM_W-1:0];
      end else begin
         term_out = quot[TERM_W-1:0];
      end
   end

endmodule

>>> rtl/incremental_speed_pid_unit.sv
// Incremental speed PID: each request carries one measured speed sample and yields one
// drive_duty, the previous drive value plus a clamped P - I + D step, clamped to
// 0..output_max. A request is registered, then the whole control law runs
// combinationally into the stored last output, which is also the response register.
// One request is taken every cycle while the response channel does not stall. Its
// response is valid once it reaches the response register. A stalled response holds
// the input register, and once that is full the request channel stalls too. The step of
// a request uses the samples and output left by the request before it. Registers are
// written through the csr channel, which is always ready; write them only while no
// request is in flight. Writes to indexes beyond output_max are ignored.
module incremental_speed_pid_unit #(
   parameter int P_TERM_LIMIT = spid_pkg::P_TERM_LIMIT_DEF,
   parameter int I_TERM_LIMIT = spid_pkg::I_TERM_LIMIT_DEF,
   parameter int D_TERM_LIMIT = spid_pkg::D_TERM_LIMIT_DEF
) (
   input logic        clock,
   input logic        reset,
   spid_req_if.sink   req_if,
   spid_rsp_if.source rsp_if,
   spid_csr_if.sink   csr_if
);
   import spid_pkg::*;

   gain_type   kp_ff, ki_ff, kd_ff;
   sample_type target_ff, step_limit_ff, output_max_ff;

   logic       in_valid_ff, rsp_valid_ff;
   sample_type sample_ff;
   sample_type prev_ff, older_ff, last_ff;
   sample_type last_in;

   logic     out_open, advance;
   diff_type p_diff, i_diff, d_diff;
   term_type p_term, i_term, d_term;

   logic signed [TERM_W+1:0] step_sum;
   logic signed [TERM_W+1:0] step_lim;
   logic signed [SAMPLE_W:0] step;
   logic signed [SAMPLE_W+1:0] new_out;

   // Register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         target_ff     <= '0;
         step_limit_ff <= STEP_LIMIT_RST;
         output_max_ff <= OUTPUT_MAX_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_KP:         kp_ff         <= gain_type'(csr_if.data);
            CSR_KI:         ki_ff         <= gain_type'(csr_if.data);
            CSR_KD:         kd_ff         <= gain_type'(csr_if.data);
            CSR_TARGET:     target_ff     <= csr_if.data[SAMPLE_W-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_if.data[SAMPLE_W-1:0];
            CSR_OUTPUT_MAX: output_max_ff <= csr_if.data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: advance the held request whenever the response slot is free
   assign out_open     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = in_valid_ff && out_open;
   assign req_if.ready = !in_valid_ff || out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         sample_ff <= req_if.measured_speed;
      end
   end

   // Error, first and second differences
   assign p_diff = $signed({3'b000, target_ff}) - $signed({3'b000, sample_ff});
   assign i_diff = $signed({3'b000, sample_ff}) - $signed({3'b000, prev_ff});
   assign d_diff = $signed({3'b000, sample_ff}) + $signed({3'b000, older_ff})
                 - $signed({2'b00, prev_ff, 1'b0});

   spid_term #(.LIMIT(P_TERM_LIMIT)) u_p_term (.gain(kp_ff), .diff(p_diff), .term_out(p_term));
   spid_term #(.LIMIT(I_TERM_LIMIT)) u_i_term (.gain(ki_ff), .diff(i_diff), .term_out(i_term));
   spid_term #(.LIMIT(D_TERM_LIMIT)) u_d_term (.gain(kd_ff), .diff(d_diff), .term_out(d_term));

   // Sum terms and clamp the step
   assign step_sum = (TERM_W+2)'(p_term) - (TERM_W+2)'(i_term) + (TERM_W+2)'(d_term);
   assign step_lim = $signed({4'b0000, step_limit_ff});

   always_comb begin
      priority if (step_sum > step_lim) begin
         step = $signed({1'b0, step_limit_ff});
      end else if (step_sum < -step_lim) begin
         step = -$signed({1'b0, step_limit_ff});
      end else begin
         step = step_sum[SAMPLE_W:0];
      end
   end

   // Accumulate and clamp the drive value
   assign new_out = $signed({2'b00, last_ff}) + (SAMPLE_W+2)'(step);

   always_comb begin
      priority if (new_out[SAMPLE_W+1]) begin
         last_in = '0;
      end else if (new_out > $signed({2'b00, output_max_ff})) begin
         last_in = output_max_ff;
      end else begin
         last_in = new_out[SAMPLE_W-1:0];
      end
   end

   // Update history and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         older_ff <= '0;
         last_ff  <= '0;
      end else if (advance) begin
         prev_ff  <= sample_ff;
         older_ff <= prev_ff;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.drive_duty = last_ff;

   // A held request with a free response slot yields a response next cycle
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("held request did not reach the response register");

   // Sample history shifts by one on each advance
   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> older_ff == $past(prev_ff) && prev_ff == $past(sample_ff))
      else $error("sample history did not shift");

   // History and output hold without an advance
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_ff) && $stable(older_ff) && $stable(last_ff))
      else $error("controller state changed without a request");

   // An accepted request is held in the input register
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> in_valid_ff)
      else $error("accepted request was lost");

endmodule
